// File: rtl/bhpr_pkg.sv
// Shared types, register map, operation codes and sequencer states for the
// bayer hot-pixel repair block. No dependencies.

package bhpr_pkg;

    // Default sizing handed to the top level's parameters.
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int PIXEL_BITS_DEF = 16;

    // Fixed field widths of the request and response beats.
    localparam int POS_W  = 8;
    localparam int PIX_W  = 16;
    localparam int CNT_W  = 5;
    localparam int DIM_W  = 9;
    localparam int CFA_W  = 8;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CFA_PATTERN  = 2'd2;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 9'd256;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 9'd256;
    localparam logic [CFA_W-1:0] CFA_PATTERN_RST  = 8'd148;

    // Operation codes; the unused code behaves as a read.
    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_REPAIR = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [PIX_W-1:0] pixel_in;
    } req_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic [CNT_W-1:0] neighbors_used;
        logic             replaced;
        logic             out_of_range;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WRITE,
        ST_READ,
        ST_READ_WAIT,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV,
        ST_STORE,
        ST_FINISH
    } state_t;

    // Colour code of a tile position: two bits per position, index (y&1)*2+(x&1).
    function automatic logic [1:0] colour_of(input logic [CFA_W-1:0] pat,
                                             input logic xb, input logic yb);
        logic [1:0] c;
        case ({yb, xb})
            2'b00:   c = pat[1:0];
            2'b01:   c = pat[3:2];
            2'b10:   c = pat[5:4];
            default: c = pat[7:6];
        endcase
        return c;
    endfunction

endpackage

// File: rtl/bayer_hot_pixel_repair_top.sv
// Bayer hot-pixel repair: frame store, neighbour-mean repair sequencer and
// APB register file in one module. Depends on bhpr_pkg.
//
// A request yields one response beat. A repair scans the 3x3 window, then
// the outer ring of the 5x5 window when the 3x3 holds no match, then divides.
// One request at a time; throughput is set by the
// one-position-per-cycle neighbour scan over the single memory read port and
// the one-bit-per-cycle shared divider. Reset clears control and the configuration
// registers; payload registers and the frame store are not cleared, and the store holds garbage until written.

module bayer_hot_pixel_repair_top
    import bhpr_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req_data,
    // response channel
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp_data,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Store sizing. The address y*w+x stays below the depth whenever the
    // position lies inside the frame, so no wrap is needed.
    localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int PROD_W    = POS_W + DIM_W + 1;
    // Sum of up to 16 neighbours.
    localparam int SUM_W     = PIXEL_BITS + CNT_W;
    localparam int DIVC_W    = $clog2(SUM_W + 1);

    localparam logic signed [2:0] RAD1_POS = 3'sd1;
    localparam logic signed [2:0] RAD2_POS = 3'sd2;
    localparam logic signed [2:0] RAD1_NEG = -3'sd1;
    localparam logic signed [2:0] RAD2_NEG = -3'sd2;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                  state_reg, state_next;
    req_t                    cmd_reg, cmd_next;
    logic [DIM_W-1:0]        fw_reg, fh_reg;
    logic [CFA_W-1:0]        cfa_reg;
    logic                    ring_reg, ring_next;       // 0: 3x3, 1: 5x5
    logic signed [2:0]       dx_reg, dx_next;
    logic signed [2:0]       dy_reg, dy_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;         // also the quotient shifter
    logic [CNT_W-1:0]        rem_reg, rem_next;
    logic [DIVC_W-1:0]       divc_reg, divc_next;
    logic                    pend_reg, pend_next;       // read data due this cycle
    rsp_t                    res_reg, res_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_t                    rsp_reg, rsp_next;
    logic [PIXEL_BITS-1:0]   rdata_reg;

    // Frame store
    logic [PIXEL_BITS-1:0]   mem [MEM_DEPTH];

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]        eff_w, eff_h;
    logic                    centre_oor;
    logic [1:0]              centre_col;
    logic signed [9:0]       nx, ny;
    logic                    nx_in, ny_in, inner_pos, is_centre, hit;
    logic                    scan_last;
    logic signed [2:0]       rad_pos, rad_neg;
    logic [POS_W-1:0]        ax, ay;
    logic [PROD_W-1:0]       addr_full;
    logic [ADDR_W-1:0]       mem_addr;
    logic                    mem_we, mem_re;
    logic [PIXEL_BITS-1:0]   mem_wdata;
    logic [CNT_W:0]          partial;
    logic                    qbit;
    logic                    cfg_wr;

    // Saturate the size registers to the store's geometry.
    assign eff_w = (32'(fw_reg) > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : fw_reg;
    assign eff_h = (32'(fh_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : fh_reg;

    assign centre_oor = ({1'b0, cmd_reg.pos_x} >= eff_w) || ({1'b0, cmd_reg.pos_y} >= eff_h);
    assign centre_col = colour_of(cfa_reg, cmd_reg.pos_x[0], cmd_reg.pos_y[0]);

    // Neighbour position under the scan cursor.
    assign nx = $signed({2'b00, cmd_reg.pos_x}) + $signed({{7{dx_reg[2]}}, dx_reg});
    assign ny = $signed({2'b00, cmd_reg.pos_y}) + $signed({{7{dy_reg[2]}}, dy_reg});
    assign nx_in = !nx[9] && (nx[8:0] < eff_w);
    assign ny_in = !ny[9] && (ny[8:0] < eff_h);
    assign is_centre = (dx_reg == 3'sd0) && (dy_reg == 3'sd0);
    // The 5x5 pass counts only the outer ring; the inner ring held no match.
    assign inner_pos = (dx_reg >= RAD1_NEG) && (dx_reg <= RAD1_POS)
                    && (dy_reg >= RAD1_NEG) && (dy_reg <= RAD1_POS);
    assign hit = nx_in && ny_in && !is_centre && !(ring_reg && inner_pos)
              && (colour_of(cfa_reg, nx[0], ny[0]) == centre_col);

    assign rad_pos   = ring_reg ? RAD2_POS : RAD1_POS;
    assign rad_neg   = ring_reg ? RAD2_NEG : RAD1_NEG;
    assign scan_last = (dx_reg == rad_pos) && (dy_reg == rad_pos);

    // Shared address unit: one multiply and add per cycle.
    assign ax        = (state_reg == ST_SCAN) ? nx[POS_W-1:0] : cmd_reg.pos_x;
    assign ay        = (state_reg == ST_SCAN) ? ny[POS_W-1:0] : cmd_reg.pos_y;
    assign addr_full = PROD_W'(ay) * PROD_W'(eff_w) + PROD_W'(ax);
    assign mem_addr  = ADDR_W'(addr_full);

    // Shared divider step: restoring, one quotient bit per cycle.
    assign partial = {rem_reg, sum_reg[SUM_W-1]};
    assign qbit    = (partial >= {1'b0, count_reg});

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                if (centre_oor)
                    state_next = ST_FINISH;
                else if (cmd_reg.mode == MODE_WRITE)
                    state_next = ST_WRITE;
                else if (cmd_reg.mode == MODE_REPAIR)
                    state_next = ST_SCAN;
                else
                    state_next = ST_READ;
            end
            ST_WRITE:     state_next = ST_FINISH;
            ST_READ:      state_next = ST_READ_WAIT;
            ST_READ_WAIT: state_next = ST_FINISH;
            ST_SCAN:
            begin
                if (scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (count_reg != '0)
                    state_next = ST_DIV;
                else if (!ring_reg)
                    state_next = ST_SCAN;
                else
                    state_next = ST_READ;
            end
            ST_DIV:
            begin
                if (divc_reg == DIVC_W'(SUM_W - 1))
                    state_next = ST_STORE;
            end
            ST_STORE:     state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        cmd_next       = cmd_reg;
        ring_next      = ring_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        divc_next      = divc_reg;
        pend_next      = 1'b0;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_wdata      = cmd_reg.pixel_in[PIXEL_BITS-1:0];

        // Fold in the neighbour fetched on the previous cycle.
        if (pend_reg)
            sum_next = sum_reg + SUM_W'(rdata_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                    cmd_next = req_data;
            end
            ST_DECODE:
            begin
                res_next              = '0;
                res_next.out_of_range = centre_oor;
                ring_next             = 1'b0;
                dx_next               = RAD1_NEG;
                dy_next               = RAD1_NEG;
                count_next            = '0;
                sum_next              = '0;
            end
            ST_WRITE:
            begin
                mem_we             = 1'b1;
                res_next.pixel_out = PIX_W'(cmd_reg.pixel_in[PIXEL_BITS-1:0]);
            end
            ST_READ:
            begin
                mem_re = 1'b1;
            end
            ST_READ_WAIT:
            begin
                res_next.pixel_out = PIX_W'(rdata_reg);
            end
            ST_SCAN:
            begin
                mem_re    = hit;
                pend_next = hit;
                if (hit)
                    count_next = count_reg + CNT_W'(1);
                if (dx_reg == rad_pos)
                begin
                    dx_next = rad_neg;
                    dy_next = dy_reg + 3'sd1;
                end
                else
                begin
                    dx_next = dx_reg + 3'sd1;
                end
            end
            ST_DRAIN:
            begin
                rem_next  = '0;
                divc_next = '0;
                if (count_reg == '0 && !ring_reg)
                begin
                    ring_next = 1'b1;
                    dx_next   = RAD2_NEG;
                    dy_next   = RAD2_NEG;
                end
            end
            ST_DIV:
            begin
                rem_next  = qbit ? CNT_W'(partial - {1'b0, count_reg}) : partial[CNT_W-1:0];
                sum_next  = {sum_reg[SUM_W-2:0], qbit};
                divc_next = divc_reg + DIVC_W'(1);
            end
            ST_STORE:
            begin
                mem_we                  = 1'b1;
                mem_wdata               = sum_reg[PIXEL_BITS-1:0];
                res_next.pixel_out      = PIX_W'(sum_reg[PIXEL_BITS-1:0]);
                res_next.neighbors_used = count_reg;
                res_next.replaced       = 1'b1;
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ring_reg      <= 1'b0;
            dx_reg        <= RAD1_NEG;
            dy_reg        <= RAD1_NEG;
            count_reg     <= '0;
            divc_reg      <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ring_reg      <= ring_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            count_reg     <= count_next;
            divc_reg      <= divc_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        sum_reg <= sum_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    // ------------------------------------------------------------------
    // Frame store: one write and one registered read per cycle
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_addr];
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg  <= FRAME_WIDTH_RST;
            fh_reg  <= FRAME_HEIGHT_RST;
            cfa_reg <= CFA_PATTERN_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[REG_IDX_W+1:2])
                REG_FRAME_WIDTH:  fw_reg  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: fh_reg  <= pwdata[DIM_W-1:0];
                REG_CFA_PATTERN:  cfa_reg <= pwdata[CFA_W-1:0];
                default:          cfa_reg <= cfa_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[REG_IDX_W+1:2])
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(fw_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(fh_reg);
            REG_CFA_PATTERN:  prdata = APB_DATA_W'(cfa_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // An accepted request holds the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while a previous one is still in work");

    // The divider remainder stays below the divisor throughout the division.
    a_rem_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < count_reg))
        else $error("divider remainder not below neighbour count");

    // A repair only writes back when it found neighbours.
    a_replaced_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.replaced) |-> (rsp_data.neighbors_used != '0))
        else $error("replacement reported without neighbours");

    // An out-of-range beat carries nothing else.
    a_oor_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.out_of_range) |->
            (rsp_data.pixel_out == '0 && !rsp_data.replaced && rsp_data.neighbors_used == '0))
        else $error("out-of-range beat carries data");
`endif

endmodule

// File: tb/bayer_hot_pixel_repair_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for bayer_hot_pixel_repair_top: directed table, then randomised phases.
// Keeps its own frame-store mirror as the predictor. Depends on bhpr_pkg and the top-level RTL.

module bayer_hot_pixel_repair_top_tb;
    import bhpr_pkg::*;

    localparam int    CLK_PERIOD       = 8;
    localparam int    RESET_CYCLES     = 12;
    localparam int    DRAIN_CYCLES     = 80;        // longer than the slowest repair
    localparam int    LONG_HOLD_CYCLES = 400;
    localparam longint TIMEOUT_CYCLES  = 1_000_000;
    localparam int    FRAME_WORDS      = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam int    MAX_PRINTED      = 40;

    // The spare mode code acts as a read; the spare register index is ignored.
    localparam logic [1:0]           MODE_READ_ALT = 2'd3;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED    = 2'd3;

    localparam rsp_t OOR_RESULT = '{pixel_out: '0, neighbors_used: '0, replaced: 1'b0,
                                    out_of_range: 1'b1};

    typedef enum bit {ROW_BEAT, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        req_t                 beat;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [31:0]          reg_val;
        bit                   typed;     // expected result written into the table
        rsp_t                 want;
    } directed_row_t;

    // One randomised phase: register settings, a working window and a beat count.
    typedef struct {
        logic [31:0] width_reg;
        logic [31:0] height_reg;
        logic [31:0] cfa_reg;
        int          x0;
        int          y0;
        int          win_w;
        int          win_h;
        int          beats;
    } phase_t;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_ready;
    req_t                  req_data;
    logic                  rsp_valid;
    logic                  rsp_ready;
    rsp_t                  rsp_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state: register mirror, frame-store mirror and which words hold data.
    logic [DIM_W-1:0] cfg_width  = FRAME_WIDTH_RST;
    logic [DIM_W-1:0] cfg_height = FRAME_HEIGHT_RST;
    logic [CFA_W-1:0] cfg_cfa    = CFA_PATTERN_RST;
    logic [PIX_W-1:0] pixel_mem     [0:FRAME_WORDS-1];
    bit               pixel_written [0:FRAME_WORDS-1];

    rsp_t pending_pixel_results [$];
    int   mismatch_count = 0;
    int   results_seen   = 0;
    bit   req_burst      = 1'b0;
    bit   rsp_burst      = 1'b0;

    directed_row_t directed_rows [$];
    phase_t        phase_plan [$];

    // Values for the 4x3 corner block at the head of the directed table.
    logic [PIX_W-1:0] corner_vals [12] = '{16'hFFFF, 16'h0000, 16'h1234, 16'hABCD,
                                           16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE,
                                           16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0};

    bayer_hot_pixel_repair_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Register values above the maximum saturate to the maximum.
    function automatic int eff_dim(input logic [DIM_W-1:0] v, input int max_dim);
        return (v > max_dim) ? max_dim : int'(v);
    endfunction

    function automatic logic [1:0] cfa_colour(input int x, input int y);
        int k;
        k = ((y & 1) << 1) | (x & 1);
        return cfg_cfa[2 * k +: 2];
    endfunction

    function automatic bit in_frame(input int x, input int y, input int w, input int h);
        return x >= 0 && x < w && y >= 0 && y < h;
    endfunction

    // Apply one request beat to the mirror and return the response it should produce.
    function automatic rsp_t predict_pixel_op(input req_t r);
        rsp_t        res;
        int          w, h, x, y, nx, ny, rad, cnt, a;
        int unsigned sum;
        logic [1:0]  col;
        res = '0;
        w   = eff_dim(cfg_width, MAX_WIDTH_DEF);
        h   = eff_dim(cfg_height, MAX_HEIGHT_DEF);
        x   = r.pos_x;
        y   = r.pos_y;
        if (x >= w || y >= h)
        begin
            res.out_of_range = 1'b1;
            return res;
        end
        a   = y * w + x;
        cnt = 0;
        if (r.mode == MODE_WRITE)
        begin
            pixel_mem[a]     = r.pixel_in;
            pixel_written[a] = 1'b1;
        end
        else if (r.mode == MODE_REPAIR)
        begin
            col = cfa_colour(x, y);
            // try the 3x3 ring first, widen to 5x5 only when it holds no match
            for (rad = 1; rad <= 2 && cnt == 0; rad++)
            begin
                sum = 0;
                for (ny = y - rad; ny <= y + rad; ny++)
                    for (nx = x - rad; nx <= x + rad; nx++)
                        if ((nx != x || ny != y) && in_frame(nx, ny, w, h)
                            && cfa_colour(nx, ny) == col)
                        begin
                            cnt++;
                            sum += pixel_mem[ny * w + nx];
                        end
                if (cnt != 0)
                begin
                    pixel_mem[a] = PIX_W'(sum / cnt);
                    res.replaced = 1'b1;
                end
            end
        end
        res.pixel_out      = pixel_mem[a];
        res.neighbors_used = CNT_W'(cnt);
        return res;
    endfunction

    // A repair is only issued when every word it may read has been written: the pixel
    // itself, the whole 3x3 window, and the 5x5 window when the 3x3 holds no match.
    function automatic bit repair_is_safe(input int x, input int y);
        int w, h, nx, ny, rad;
        bit hit;
        w   = eff_dim(cfg_width, MAX_WIDTH_DEF);
        h   = eff_dim(cfg_height, MAX_HEIGHT_DEF);
        hit = 1'b0;
        if (!pixel_written[y * w + x])
            return 1'b0;
        for (rad = 1; rad <= 2; rad++)
        begin
            for (ny = y - rad; ny <= y + rad; ny++)
                for (nx = x - rad; nx <= x + rad; nx++)
                    if (in_frame(nx, ny, w, h))
                    begin
                        if (!pixel_written[ny * w + nx])
                            return 1'b0;
                        if ((nx != x || ny != y) && cfa_colour(nx, ny) == cfa_colour(x, y))
                            hit = 1'b1;
                    end
            if (hit)
                return 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic void take_register(input logic [REG_IDX_W-1:0] idx,
                                          input logic [31:0] val);
        case (idx)
            REG_FRAME_WIDTH:  cfg_width  = val[DIM_W-1:0];
            REG_FRAME_HEIGHT: cfg_height = val[DIM_W-1:0];
            REG_CFA_PATTERN:  cfg_cfa    = val[CFA_W-1:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Per-beat idle draw; now and then flip into or out of a stretch with no idling.
    function automatic int next_gap(inout bit burst);
        if ($urandom_range(0, 19) == 0)
            burst = !burst;
        return burst ? 0 : int'($urandom_range(0, 19));
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return PIX_W'($urandom);
    endfunction

    function automatic directed_row_t beat_row(input logic [1:0] mode, input int x, input int y,
                                               input logic [PIX_W-1:0] pix, input bit typed,
                                               input rsp_t want);
        directed_row_t row;
        row.kind           = ROW_BEAT;
        row.beat.mode      = mode;
        row.beat.pos_x     = POS_W'(x);
        row.beat.pos_y     = POS_W'(y);
        row.beat.pixel_in  = pix;
        row.reg_idx        = '0;
        row.reg_val        = '0;
        row.typed          = typed;
        row.want           = want;
        return row;
    endfunction

    function automatic directed_row_t reg_row(input logic [REG_IDX_W-1:0] idx,
                                              input logic [31:0] val);
        directed_row_t row;
        row.kind    = ROW_REG;
        row.beat    = '0;
        row.reg_idx = idx;
        row.reg_val = val;
        row.typed   = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    function automatic phase_t make_phase(input logic [31:0] wr, input logic [31:0] hr,
                                          input logic [31:0] cr, input int x0, input int y0,
                                          input int ww, input int wh, input int beats);
        phase_t p;
        p.width_reg  = wr;
        p.height_reg = hr;
        p.cfa_reg    = cr;
        p.x0         = x0;
        p.y0         = y0;
        p.win_w      = ww;
        p.win_h      = wh;
        p.beats      = beats;
        return p;
    endfunction

    // Append to the directed table and to the phase plan.
    function automatic void add_row(input directed_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_phase(input phase_t p);
        phase_plan.insert(phase_plan.size(), p);
    endfunction

    // Draw one random beat. Mostly inside the filled window; a few strays land outside
    // the frame. Reads and repairs that would touch unwritten words become writes.
    function automatic req_t draw_req(input int x0, input int y0, input int xe, input int ye,
                                      input int w, input int h);
        req_t r;
        int   x, y, pick;
        bit   stray;
        r.pixel_in = pick_pixel();
        stray = (xe <= x0) || (ye <= y0)
                || ((w < MAX_WIDTH_DEF || h < MAX_HEIGHT_DEF) && $urandom_range(0, 99) < 8);
        if (stray)
        begin
            r.mode = 2'($urandom_range(0, 3));
            if (w < MAX_WIDTH_DEF && (h >= MAX_HEIGHT_DEF || $urandom_range(0, 1) == 1))
            begin
                x = $urandom_range(w, 255);
                y = $urandom_range(0, 255);
            end
            else
            begin
                x = $urandom_range(0, 255);
                y = $urandom_range(h, 255);
            end
        end
        else
        begin
            x    = $urandom_range(x0, xe - 1);
            y    = $urandom_range(y0, ye - 1);
            pick = $urandom_range(0, 99);
            if (pick < 30)
                r.mode = MODE_WRITE;
            else if (pick < 65)
                r.mode = repair_is_safe(x, y) ? MODE_REPAIR : MODE_WRITE;
            else if (pick < 90)
                r.mode = pixel_written[y * w + x] ? MODE_READ : MODE_WRITE;
            else
                r.mode = pixel_written[y * w + x] ? MODE_READ_ALT : MODE_WRITE;
        end
        r.pos_x = POS_W'(x);
        r.pos_y = POS_W'(y);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Bus tasks (entered and left at a falling edge)
    // ------------------------------------------------------------------

    // Offer one request beat after a random idle; hold it until accepted, then log
    // the expectation. Valid stays high into the next call so back-to-back beats
    // need no extra edge.
    task automatic send_req(input req_t r, input bit typed, input rsp_t want);
        int   gap;
        rsp_t pred;
        gap = next_gap(req_burst);
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_data  = r;
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        pred = predict_pixel_op(r);
        pending_pixel_results.insert(pending_pixel_results.size(), typed ? want : pred);
        @(negedge clk);
    endtask

    // Drop valid, wait for every expected beat, then let the block settle.
    task automatic wait_drained();
        req_valid = 1'b0;
        while (pending_pixel_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Setup cycle, then access cycle; the write lands on the edge where pready is seen.
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_W'({idx, 2'b00});
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        take_register(idx, val);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic run_phase(input phase_t p);
        int w, h, xe, ye, x, y, i;
        req_t r;
        wait_drained();
        reg_write(REG_FRAME_WIDTH, p.width_reg);
        reg_write(REG_FRAME_HEIGHT, p.height_reg);
        reg_write(REG_CFA_PATTERN, p.cfa_reg);
        w  = eff_dim(cfg_width, MAX_WIDTH_DEF);
        h  = eff_dim(cfg_height, MAX_HEIGHT_DEF);
        xe = (p.x0 + p.win_w < w) ? p.x0 + p.win_w : w;
        ye = (p.y0 + p.win_h < h) ? p.y0 + p.win_h : h;
        // fill the window so later reads and repairs stay on written words
        for (y = p.y0; y < ye; y++)
            for (x = p.x0; x < xe; x++)
            begin
                r.mode     = MODE_WRITE;
                r.pos_x    = POS_W'(x);
                r.pos_y    = POS_W'(y);
                r.pixel_in = pick_pixel();
                send_req(r, 1'b0, '0);
            end
        for (i = 0; i < p.beats; i++)
            send_req(draw_req(p.x0, p.y0, xe, ye, w, h), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic check_result(input rsp_t got);
        rsp_t want;
        if (pending_pixel_results.size() == 0)
        begin
            report_mismatch($sformatf("response beat %h with nothing outstanding", got));
            return;
        end
        want = pending_pixel_results.pop_front();
        if (got.pixel_out !== want.pixel_out)
            report_mismatch($sformatf("pixel_out %h, expected %h",
                                      got.pixel_out, want.pixel_out));
        if (got.neighbors_used !== want.neighbors_used)
            report_mismatch($sformatf("neighbors_used %0d, expected %0d",
                                      got.neighbors_used, want.neighbors_used));
        if (got.replaced !== want.replaced)
            report_mismatch($sformatf("replaced %b, expected %b", got.replaced, want.replaced));
        if (got.out_of_range !== want.out_of_range)
            report_mismatch($sformatf("out_of_range %b, expected %b",
                                      got.out_of_range, want.out_of_range));
    endtask

    // Response side: random stall before each beat, plus two long hold-offs so the
    // block backs up and has to stall its request side while beats keep coming.
    initial
    begin
        int gap;
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = next_gap(rsp_burst);
            if (results_seen == 300 || results_seen == 1100)
                gap = LONG_HOLD_CYCLES;
            if (gap > 0)
            begin
                rsp_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ready = 1'b1;
            do
                @(posedge clk);
            while (rsp_valid !== 1'b1);
            check_result(rsp_data);
            results_seen++;
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        directed_row_t row;
        int i;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;

        // Directed table, starting from the reset register values (256x256, RGGB-style).
        // Fill a 4x3 corner block with extreme and patterned values.
        for (i = 0; i < 12; i++)
            add_row(beat_row(MODE_WRITE, i % 4, i / 4, corner_vals[i], 1'b1,
                             '{pixel_out: corner_vals[i], neighbors_used: '0,
                               replaced: 1'b0, out_of_range: 1'b0}));
        // Corner pixel: no match in 3x3, so the repair widens to 5x5.
        add_row(beat_row(MODE_REPAIR, 0, 0, '1, 1'b0, '0));
        // Edge green with two matches, then an inner green with four.
        add_row(beat_row(MODE_REPAIR, 1, 0, '0, 1'b0, '0));
        add_row(beat_row(MODE_REPAIR, 2, 1, 16'h1357, 1'b0, '0));
        add_row(beat_row(MODE_READ, 3, 2, '1, 1'b0, '0));
        add_row(beat_row(MODE_READ_ALT, 0, 0, '0, 1'b0, '0));
        // Narrow the frame: positions past the width are refused untouched.
        add_row(reg_row(REG_FRAME_WIDTH, 32'd4));
        add_row(beat_row(MODE_WRITE, 4, 0, '1, 1'b1, OOR_RESULT));
        add_row(beat_row(MODE_READ, 255, 255, '1, 1'b1, OOR_RESULT));
        // Zero height: every position is outside the frame.
        add_row(reg_row(REG_FRAME_HEIGHT, 32'd0));
        add_row(beat_row(MODE_REPAIR, 0, 0, '0, 1'b1, OOR_RESULT));
        // Oversized height saturates; a write past the register list is dropped.
        add_row(reg_row(REG_FRAME_HEIGHT, 32'd511));
        add_row(reg_row(REG_UNUSED, 32'd0));
        add_row(beat_row(MODE_READ_ALT, 3, 0, 16'hA5A5, 1'b0, '0));

        // Random phases: settings, window, beat count.
        add_phase(make_phase(256, 256, 148, 120, 60, 10, 10, 150));
        add_phase(make_phase(6, 5, 8'h1B, 0, 0, 6, 5, 160));      // all colours apart
        add_phase(make_phase(1, 1, 8'h00, 0, 0, 1, 1, 50));       // no neighbours
        add_phase(make_phase(511, 4, 8'hFF, 248, 0, 8, 4, 180));  // right edge
        add_phase(make_phase(12, 300, 8'h6C, 0, 248, 12, 8, 180)); // bottom rows
        add_phase(make_phase(0, 8, 8'h55, 0, 0, 8, 8, 40));       // zero width
        add_phase(make_phase(256, 1, 8'hE4, 0, 0, 10, 1, 60));    // single row
        for (i = 0; i < 2; i++)
            add_phase(make_phase($urandom_range(1, 12), $urandom_range(1, 12),
                                 $urandom_range(0, 255), 0, 0, 12, 12, 150));

        // Hold reset, then release it on a falling edge.
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed table; register rows wait for the block to go idle.
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_REG)
            begin
                wait_drained();
                reg_write(row.reg_idx, row.reg_val);
            end
            else
                send_req(row.beat, row.typed, row.want);
        end

        foreach (phase_plan[i])
            run_phase(phase_plan[i]);

        // Let every outstanding beat come back, then settle before the verdict.
        wait_drained();
        if (mismatch_count == 0)
            $display("bayer_hot_pixel_repair_top verification clean");
        else
            $display("bayer_hot_pixel_repair_top verification failed");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("bayer_hot_pixel_repair_top verification failed");
        $finish;
    end

endmodule
